@@ rtl/spq_pkg.sv @@
// Package for the sorted-insert priority queue.
// Holds the command and status codes, the key type and the structs that pass
// between the top level, the cells and the result buffer. Depends on nothing.
package spq_pkg;

   localparam int KEY_W = 32;

   typedef logic signed [KEY_W-1:0] key_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DELETE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // Broadcast from the control logic to every cell of the chain
   typedef struct packed {
      logic    ins;
      logic    del;
      key_type key;
   } cell_ctl_type;

   // One result transaction
   typedef struct packed {
      status_type status;
      key_type    key;
   } result_type;

endpackage

@@ rtl/sorted_insert_priority_queue.sv @@
// Top level of the sorted-insert minimum priority queue.
// Instantiates the chain of spq_cell slots and the spq_out_buf result buffer;
// depends on spq_pkg.
//
//   channel   ports                                  direction
//   request   req_valid req_stall req_cmd req_key_in in (stall out)
//   response  rsp_valid rsp_stall rsp_status rsp_key_out out (stall in)
//
// One transaction per cycle while req_stall is low: every cell compares and shifts
// in the same cycle, so the length of the chain does not limit the rate, and each
// result is registered in the result buffer before it leaves.
// The smallest key always sits in cell 0; a delete shifts the chain left.
// Reset (synchronous) empties the queue and the result buffer; keys are not cleared.
// req_stall rises only when both result buffer entries are held by a stalled consumer.
module sorted_insert_priority_queue #(
   parameter int DEPTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  logic signed [31:0]     req_key_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic signed [31:0]     rsp_key_out
);
   import spq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             holds_ff, holds_in;
   logic [IDX_W-1:0] span;
   logic             accept;
   logic             is_insert;
   logic             full;
   logic             buf_full;
   cell_ctl_type     ctl;
   result_type       result;
   result_type       rsp_data;
   logic [DEPTH-1:0] occ;
   logic [DEPTH-1:0] gt;
   key_type          cell_key [DEPTH];

   assign accept    = req_valid && !req_stall;
   assign is_insert = (cmd_type'(req_cmd) == CMD_INSERT);
   assign full      = holds_ff && (tail_ff == IDX_W'(DEPTH - 1));
   assign span      = tail_ff - head_ff;

   // Broadcast the operation to the cells
   always_comb begin
      ctl.ins = accept && is_insert && !full;
      ctl.del = accept && !is_insert && holds_ff;
      ctl.key = req_key_in;
   end

   // Mark the cells that hold queued keys
   for (genvar i = 0; i < DEPTH; i++) begin : g_occ
      assign occ[i] = holds_ff && (IDX_W'(i) <= span);
   end

   // Chain of cells; inner cells link to both neighbors, the end cells to one
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic    occ_left;
      logic    gt_left;
      key_type key_left;
      key_type key_right;

      if (i == 0) begin : g_first
         assign occ_left = 1'b1;
         assign gt_left  = 1'b0;
         assign key_left = '0;
      end else begin : g_inner
         assign occ_left = occ[i-1];
         assign gt_left  = gt[i-1];
         assign key_left = cell_key[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign key_right = cell_key[i];
      end else begin : g_body
         assign key_right = cell_key[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .occ_self  (occ[i]),
         .occ_left  (occ_left),
         .gt_left   (gt_left),
         .key_left  (key_left),
         .key_right (key_right),
         .gt_self   (gt[i]),
         .slot_key  (cell_key[i])
      );
   end

   // Update head and tail indices
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      holds_in = holds_ff;
      if (ctl.ins) begin
         if (!holds_ff) begin
            head_in  = '0;
            tail_in  = '0;
            holds_in = 1'b1;
         end else begin
            tail_in = tail_ff + 1'b1;
         end
      end else if (ctl.del) begin
         if (head_ff == tail_ff) begin
            head_in  = '0;
            tail_in  = '0;
            holds_in = 1'b0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         holds_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         holds_ff <= holds_in;
      end
   end

   // Form the result transaction
   always_comb begin
      result.status = ST_OK;
      result.key    = '0;
      if (is_insert) begin
         if (full) begin
            result.status = ST_OVERFLOW;
         end
      end else if (holds_ff) begin
         result.key = cell_key[0];
      end else begin
         result.status = ST_UNDERFLOW;
      end
   end

   spq_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .pop_stall (rsp_stall),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   assign req_stall   = buf_full;
   assign rsp_status  = rsp_data.status;
   assign rsp_key_out = rsp_data.key;

`ifndef SYNTHESIS
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result pending");

   a_empty_indices: assert property (@(posedge clock) disable iff (reset)
      !holds_ff |-> (head_ff == '0) && (tail_ff == '0))
      else $error("empty queue with nonzero indices");

   a_tail_not_below_head: assert property (@(posedge clock) disable iff (reset)
      holds_ff |-> (tail_ff >= head_ff))
      else $error("tail index below head index");

   a_insert_fills: assert property (@(posedge clock) disable iff (reset)
      ctl.ins |=> holds_ff)
      else $error("queue empty after an insert");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      occ[1] |-> (cell_key[0] <= cell_key[1]))
      else $error("front of the key chain out of order");
`endif

endmodule

@@ rtl/spq_cell.sv @@
// One slot of the sorted key chain.
// Compares its key with the broadcast key; on insert takes a key from its left
// neighbor or the broadcast key, on delete from its right neighbor. Depends on spq_pkg.
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  logic                  occ_self,
   input  logic                  occ_left,
   input  logic                  gt_left,
   input  spq_pkg::key_type      key_left,
   input  spq_pkg::key_type      key_right,
   output logic                  gt_self,
   output spq_pkg::key_type      slot_key
);
   import spq_pkg::*;

   key_type slot_key_ff;
   key_type slot_key_in;

   // Flag an occupied slot whose key sorts after the new key
   assign gt_self = occ_self && (slot_key_ff > ctl.key);

   // Shift right past the insert point, drop in the new key, or shift left on delete
   always_comb begin
      slot_key_in = slot_key_ff;
      if (ctl.ins) begin
         if (gt_left) begin
            slot_key_in = key_left;
         end else if (gt_self || (!occ_self && occ_left)) begin
            slot_key_in = ctl.key;
         end
      end else if (ctl.del) begin
         slot_key_in = key_right;
      end
   end

   always_ff @(posedge clock) begin
      slot_key_ff <= slot_key_in;
   end

   assign slot_key = slot_key_ff;

endmodule

@@ rtl/spq_out_buf.sv @@
// Two-entry result buffer that parts the request side from the response side.
// Holds a result while the consumer stalls and still takes one more.
// Depends on spq_pkg.
module spq_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  spq_pkg::result_type push_data,
   input  logic                pop_stall,
   output logic                full,
   output logic                out_valid,
   output spq_pkg::result_type out_data
);
   import spq_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_data_ff, main_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop = main_valid_ff && !pop_stall;

   // Advance the skid entry into the main slot, load the new transaction, or park it in the skid entry
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end else begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

@@ test/spq_checker.sv @@
// Checker for the sorted-insert priority queue: watches both channels, predicts
// each result from its own copy of the sorted store and compares field by field.
// Depends on spq_pkg for the command, status, key and result types.
module spq_checker #(
   parameter int DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [31:0] req_key_in,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_key_out,
   output int                 errors,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   // Predicted queue contents: ascending keys from head_slot to tail_slot
   key_type     slots [DEPTH];
   int unsigned head_slot;
   int unsigned tail_slot;
   bit          occupied;

   result_type  expected_results [$];

   initial begin
      errors  = 0;
      pending = 0;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      $display("%0t ns  spq_checker: %s", $time, msg);
   endtask

   // Apply one transaction to the predicted queue and return its result
   function automatic result_type queue_op(input cmd_type op, input key_type key);
      result_type  res;
      int unsigned j;
      res.status = ST_OK;
      res.key    = '0;
      if (op == CMD_INSERT) begin
         if (!occupied) begin
            head_slot = 0;
            tail_slot = 0;
            slots[0]  = key;
            occupied  = 1'b1;
         end else if (tail_slot >= DEPTH - 1) begin
            res.status = ST_OVERFLOW;
         end else begin
            // shift larger keys up one slot; equal keys stay ahead
            j = tail_slot + 1;
            while (j > head_slot && slots[j-1] > key) begin
               slots[j] = slots[j-1];
               j--;
            end
            slots[j]  = key;
            tail_slot = tail_slot + 1;
         end
      end else begin
         if (!occupied) begin
            res.status = ST_UNDERFLOW;
         end else begin
            res.key = slots[head_slot];
            if (head_slot == tail_slot) begin
               occupied  = 1'b0;
               head_slot = 0;
               tail_slot = 0;
            end else begin
               head_slot = head_slot + 1;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         head_slot = 0;
         tail_slot = 0;
         occupied  = 1'b0;
         expected_results.delete();
      end else begin
         // check an outgoing result against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d key %0d",
                                         rsp_status, rsp_key_out));
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_key_out !== want.key)
                  report_mismatch($sformatf("key_out %0d, expected %0d",
                                            rsp_key_out, want.key));
            end
         end
         // predict the result of an accepted transaction
         if (req_valid && !req_stall)
            expected_results.push_back(queue_op(cmd_type'(req_cmd), req_key_in));
      end
      pending = expected_results.size();
   end

endmodule

@@ test/tb_sorted_insert_priority_queue.sv @@
// Testbench top for sorted_insert_priority_queue: drives directed and random
// insert/delete transactions under varying idle profiles and gives the verdict.
// Depends on spq_pkg, the block itself and spq_checker.
module tb_sorted_insert_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   localparam int DEPTH      = 8;
   localparam int PHASE_OPS  = 150;
   localparam key_type KEY_MAX = 32'sh7fff_ffff;
   localparam key_type KEY_MIN = 32'sh8000_0000;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic        req_cmd     = CMD_INSERT;
   key_type     req_key_in  = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [1:0]  rsp_status;
   key_type     rsp_key_out;

   int          errors;
   int          pending;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          inserts_sent  = 0;
   int          deletes_sent  = 0;

   sorted_insert_priority_queue #(.DEPTH(DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_key_in  (req_key_in),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_key_out (rsp_key_out)
   );

   spq_checker #(.DEPTH(DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_key_in  (req_key_in),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_key_out (rsp_key_out),
      .errors      (errors),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stall the result channel at the current idle rate
   always @(posedge clock) begin
      rsp_stall <= (int'($urandom_range(99)) < recv_idle_pct);
   end

   // Present one transaction and hold it until it is taken
   task automatic send_op(input cmd_type op, input key_type key);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= op;
      req_key_in <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == CMD_INSERT) inserts_sent++;
      else                  deletes_sent++;
   endtask

   // Mix of full-width, clustered and extreme keys so ties happen often
   function automatic key_type pick_key();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6, 7: return int'($urandom_range(8)) - 4;
         8:          return $urandom_range(1) ? KEY_MAX : KEY_MIN;
         default:    return int'($urandom_range(255)) << 24;
      endcase
   endfunction

   // Bursts that lean toward filling, draining or neither
   task automatic random_phase(input int count);
      int sent;
      int burst;
      int ins_pct;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(16, 4);
         case ($urandom_range(2))
            0:       ins_pct = 85;
            1:       ins_pct = 20;
            default: ins_pct = 50;
         endcase
         repeat (burst) begin
            if (int'($urandom_range(99)) < ins_pct) send_op(CMD_INSERT, pick_key());
            else                                    send_op(CMD_DELETE, $urandom);
            sent++;
         end
      end
   endtask

   // Drop valid and hold off until every result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: underflow, extremes, ties, fill to full, overflow, drain
      send_idle_pct <= 19;
      recv_idle_pct <= 60;
      send_op(CMD_DELETE, $urandom);
      send_op(CMD_INSERT, 0);
      send_op(CMD_INSERT, KEY_MAX);
      send_op(CMD_INSERT, KEY_MIN);
      send_op(CMD_INSERT, 5);
      send_op(CMD_INSERT, 5);
      send_op(CMD_INSERT, -1);
      send_op(CMD_INSERT, KEY_MAX);
      send_op(CMD_INSERT, KEY_MIN);
      send_op(CMD_INSERT, 3);
      repeat (8) send_op(CMD_DELETE, $urandom);
      send_op(CMD_DELETE, KEY_MAX);
      send_op(CMD_INSERT, -7);
      send_op(CMD_DELETE, '0);
      send_op(CMD_INSERT, 1);
      send_op(CMD_INSERT, 2);
      send_op(CMD_DELETE, $urandom);
      send_op(CMD_INSERT, 0);

      // Random, sender idles lightly, receiver heavily
      random_phase(PHASE_OPS);
      drain();

      // Swap the idle rates
      send_idle_pct <= 60;
      recv_idle_pct <= 19;
      random_phase(PHASE_OPS);
      drain();

      // Full throughput on both sides
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      random_phase(PHASE_OPS);
      drain();
      repeat (10) @(posedge clock);

      $display("%0d transactions (%0d inserts, %0d deletes) over three idle profiles",
               inserts_sent + deletes_sent, inserts_sent, deletes_sent);
      $display("%0d mismatches, %0d results still outstanding", errors, pending);
      if (errors == 0 && pending == 0)
         $display("tb_sorted_insert_priority_queue: done, clean");
      else
         $display("tb_sorted_insert_priority_queue: done, errors");
      $finish;
   end

   // Hard stop if the handshake hangs
   initial begin
      #400us;
      $display("tb_sorted_insert_priority_queue: done, errors");
      $finish;
   end

endmodule
